@@ rtl/core/drc_pkg.sv @@
`timescale 1ns / 1ps

package drc_pkg;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int WEEK_W  = 3;
   localparam int WDAY_W  = 3;
   localparam int KEY_W   = MONTH_W + DAY_W + HOUR_W;
   localparam int YY_W    = 13;
   localparam int Q100_W  = 7;
   localparam int QLEAP_W = 6;
   localparam int Q7_W    = 10;

   localparam logic [YY_W-1:0]    YEAR_BIAS   = 13'd400;
   localparam logic [10:0]        DIV25_MUL   = 11'd1311;
   localparam int                 DIV25_SHIFT = 15;
   localparam logic [13:0]        DIV7_MUL    = 14'd9363;
   localparam int                 DIV7_SHIFT  = 16;
   localparam logic [WEEK_W-1:0]  WEEK_LAST   = 3'd5;
   localparam logic [WDAY_W-1:0]  WDAY_WRAP   = 3'd7;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

   typedef enum logic [2:0] {
      REG_DST_MONTH   = 3'd0,
      REG_DST_WEEK    = 3'd1,
      REG_DST_WEEKDAY = 3'd2,
      REG_DST_HOUR    = 3'd3,
      REG_STD_MONTH   = 3'd4,
      REG_STD_WEEK    = 3'd5,
      REG_STD_WEEKDAY = 3'd6,
      REG_STD_HOUR    = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
   } stamp_type;

   typedef struct packed {
      logic [MONTH_W-1:0] month;
      logic [WEEK_W-1:0]  week;
      logic [WDAY_W-1:0]  wday;
      logic [HOUR_W-1:0]  hour;
   } rule_type;

   function automatic logic [2:0] month_offs(input logic [MONTH_W-1:0] m);
      logic [2:0] r;
      case (m)
         4'd1:    r = 3'd0;
         4'd2:    r = 3'd3;
         4'd3:    r = 3'd2;
         4'd4:    r = 3'd5;
         4'd5:    r = 3'd0;
         4'd6:    r = 3'd3;
         4'd7:    r = 3'd5;
         4'd8:    r = 3'd1;
         4'd9:    r = 3'd4;
         4'd10:   r = 3'd6;
         4'd11:   r = 3'd2;
         4'd12:   r = 3'd4;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] r;
      case (m)
         4'd2:                   r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default:                r = 5'd31;
      endcase
      return r;
   endfunction

   function automatic rule_type rule_clamp(input logic [MONTH_W-1:0] m,
                                           input logic [WEEK_W-1:0]  wk,
                                           input logic [WDAY_W-1:0]  wd,
                                           input logic [HOUR_W-1:0]  hr);
      rule_type r;
      r.month = (m == '0) ? 4'd1 : ((m > MONTH_DEC) ? MONTH_DEC : m);
      r.week  = (wk == '0) ? 3'd1 : ((wk > WEEK_LAST) ? WEEK_LAST : wk);
      r.wday  = (wd == WDAY_WRAP) ? 3'd0 : wd;
      r.hour  = hr;
      return r;
   endfunction

endpackage

@@ rtl/core/dst_rule_check_core.sv @@
// DST rule check: one query (year, month, day, hour) enters per cycle when req_ready is high and
// its in_dst answer appears on the rsp_ channel after the four register stages (rule year terms,
// weekday sums, transition day, compare); the whole pipeline holds while a finished answer waits
// on rsp_ready. The eight rule registers sit on the csr_ port at byte addresses 0 to 28 in steps
// of 4 and may only be changed while no query is in flight. A DST month of zero forces in_dst low.
`timescale 1ns / 1ps

module dst_rule_check_core
   import drc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [YEAR_W-1:0]       req_year,
   input  logic [MONTH_W-1:0]      req_month,
   input  logic [DAY_W-1:0]        req_day,
   input  logic [HOUR_W-1:0]       req_hour,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_in_dst,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [4:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   logic [MONTH_W-1:0] dst_month_ff, std_month_ff;
   logic [WEEK_W-1:0]  dst_week_ff, std_week_ff;
   logic [WDAY_W-1:0]  dst_weekday_ff, std_weekday_ff;
   logic [HOUR_W-1:0]  dst_hour_ff, std_hour_ff;
   logic               csr_wr;
   reg_idx_type        csr_idx;

   rule_type           rule [2];
   logic               adv;

   // stage A
   logic               va_ff;
   stamp_type          now_a_ff, now_a_in;
   logic [YEAR_W-1:0]  year_a_ff;
   logic [YY_W-1:0]    yy_a_ff [2];
   logic [YY_W-1:0]    yy_a_in [2];
   logic [Q100_W-1:0]  q100_a_ff [2];
   logic [Q100_W-1:0]  q100_a_in [2];
   logic [QLEAP_W-1:0] qleap_a_ff, qleap_a_in;
   logic [21:0]        p25 [2];
   logic [20:0]        pleap;

   // stage B
   logic               vb_ff;
   stamp_type          now_b_ff;
   logic               leap_b_ff, leap_b_in;
   logic [YY_W-1:0]    s_b_ff [2];
   logic [YY_W-1:0]    s_b_in [2];
   logic [Q7_W-1:0]    q7_b_ff [2];
   logic [Q7_W-1:0]    q7_b_in [2];
   logic [26:0]        p7 [2];

   // stage C
   logic               vc_ff;
   stamp_type          now_c_ff;
   logic [DAY_W-1:0]   day_c_ff [2];
   logic [DAY_W-1:0]   day_c_in [2];

   // stage D
   logic               rsp_valid_ff;
   logic               rsp_in_dst_ff, rsp_in_dst_in;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_month_ff   <= '0;
         dst_week_ff    <= 3'd1;
         dst_weekday_ff <= '0;
         dst_hour_ff    <= '0;
         std_month_ff   <= 4'd1;
         std_week_ff    <= 3'd1;
         std_weekday_ff <= '0;
         std_hour_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_DST_MONTH:   dst_month_ff   <= csr_pwdata[MONTH_W-1:0];
            REG_DST_WEEK:    dst_week_ff    <= csr_pwdata[WEEK_W-1:0];
            REG_DST_WEEKDAY: dst_weekday_ff <= csr_pwdata[WDAY_W-1:0];
            REG_DST_HOUR:    dst_hour_ff    <= csr_pwdata[HOUR_W-1:0];
            REG_STD_MONTH:   std_month_ff   <= csr_pwdata[MONTH_W-1:0];
            REG_STD_WEEK:    std_week_ff    <= csr_pwdata[WEEK_W-1:0];
            REG_STD_WEEKDAY: std_weekday_ff <= csr_pwdata[WDAY_W-1:0];
            REG_STD_HOUR:    std_hour_ff    <= csr_pwdata[HOUR_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_DST_MONTH:   csr_prdata = 32'(dst_month_ff);
         REG_DST_WEEK:    csr_prdata = 32'(dst_week_ff);
         REG_DST_WEEKDAY: csr_prdata = 32'(dst_weekday_ff);
         REG_DST_HOUR:    csr_prdata = 32'(dst_hour_ff);
         REG_STD_MONTH:   csr_prdata = 32'(std_month_ff);
         REG_STD_WEEK:    csr_prdata = 32'(std_week_ff);
         REG_STD_WEEKDAY: csr_prdata = 32'(std_weekday_ff);
         REG_STD_HOUR:    csr_prdata = 32'(std_hour_ff);
      endcase
   end

   assign rule[0] = rule_clamp(dst_month_ff, dst_week_ff, dst_weekday_ff, dst_hour_ff);
   assign rule[1] = rule_clamp(std_month_ff, std_week_ff, std_weekday_ff, std_hour_ff);

   // advance every stage together; hold all while the answer waits
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage A: year terms and the divide by 100 of each rule's year and of the request year
   always_comb begin
      now_a_in.month = req_month;
      now_a_in.day   = req_day;
      now_a_in.hour  = req_hour;
      for (int r = 0; r < 2; r++) begin
         yy_a_in[r]   = 13'(req_year) + YEAR_BIAS
                        - ((rule[r].month < MONTH_MAR) ? 13'd1 : 13'd0);
         p25[r]       = 22'(yy_a_in[r][YY_W-1:2]) * 22'(DIV25_MUL);
         q100_a_in[r] = p25[r][DIV25_SHIFT +: Q100_W];
      end
      pleap      = 21'(req_year[YEAR_W-1:2]) * 21'(DIV25_MUL);
      qleap_a_in = pleap[DIV25_SHIFT +: QLEAP_W];
   end

   // stage B: leap flag, weekday sum and the divide by 7
   always_comb begin
      leap_b_in = (year_a_ff[1:0] == 2'd0)
                  && ((year_a_ff[YEAR_W-1:2] != 10'(qleap_a_ff * 6'd25))
                      || (qleap_a_ff[1:0] == 2'd0));
      for (int r = 0; r < 2; r++) begin
         s_b_in[r]  = yy_a_ff[r] + 13'(yy_a_ff[r][YY_W-1:2]) - 13'(q100_a_ff[r])
                      + 13'(q100_a_ff[r][Q100_W-1:2]) + 13'(month_offs(rule[r].month))
                      + 13'd1;
         p7[r]      = 27'(s_b_in[r]) * 27'(DIV7_MUL);
         q7_b_in[r] = p7[r][DIV7_SHIFT +: Q7_W];
      end
   end

   // stage C: transition day in the rule month
   always_comb begin
      logic [YY_W-1:0]  rem;
      logic [2:0]       first;
      logic [3:0]       t;
      logic [DAY_W-1:0] d;
      logic [DAY_W-1:0] dim;
      rem   = '0;
      first = '0;
      t     = '0;
      d     = '0;
      dim   = '0;
      for (int r = 0; r < 2; r++) begin
         rem   = s_b_ff[r] - 13'(13'(q7_b_ff[r]) * 13'd7);
         first = rem[2:0];
         t     = 4'(rule[r].wday) + 4'd7 - 4'(first);
         if (t >= 4'd7) begin
            t = t - 4'd7;
         end
         d   = 5'(t) + 5'd1;
         dim = month_days(rule[r].month, leap_b_ff);
         if (rule[r].week == WEEK_LAST) begin
            day_c_in[r] = (6'(d) + 6'd28 <= 6'(dim)) ? d + 5'd28 : d + 5'd21;
         end else begin
            day_c_in[r] = d + 5'(5'(rule[r].week - 3'd1) * 5'd7);
         end
      end
   end

   // stage D: compare against both transitions
   always_comb begin
      logic [KEY_W-1:0] now_key;
      logic [KEY_W-1:0] start_key;
      logic [KEY_W-1:0] end_key;
      now_key   = now_c_ff;
      start_key = {rule[0].month, day_c_ff[0], rule[0].hour};
      end_key   = {rule[1].month, day_c_ff[1], rule[1].hour};
      if (dst_month_ff == '0) begin
         rsp_in_dst_in = 1'b0;
      end else if (end_key < start_key) begin
         rsp_in_dst_in = (now_key >= start_key) || (now_key < end_key);
      end else begin
         rsp_in_dst_in = (now_key >= start_key) && (now_key < end_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         va_ff        <= req_valid;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         rsp_valid_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         now_a_ff      <= now_a_in;
         year_a_ff     <= req_year;
         qleap_a_ff    <= qleap_a_in;
         now_b_ff      <= now_a_ff;
         leap_b_ff     <= leap_b_in;
         now_c_ff      <= now_b_ff;
         rsp_in_dst_ff <= rsp_in_dst_in;
         for (int r = 0; r < 2; r++) begin
            yy_a_ff[r]   <= yy_a_in[r];
            q100_a_ff[r] <= q100_a_in[r];
            s_b_ff[r]    <= s_b_in[r];
            q7_b_ff[r]   <= q7_b_in[r];
            day_c_ff[r]  <= day_c_in[r];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_in_dst = rsp_in_dst_ff;

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> va_ff)
      else $error("accepted transfer did not enter stage A");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      vc_ff && !req_ready |=> vc_ff)
      else $error("stage C lost its item during a stall");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vc_ff))
      else $error("result appeared without an item in stage C");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      vc_ff |-> (day_c_ff[0] >= 5'd1) && (day_c_ff[0] <= 5'd31)
             && (day_c_ff[1] >= 5'd1) && (day_c_ff[1] <= 5'd31))
      else $error("transition day out of range");

endmodule

@@ tb/in_dst_checker.sv @@
`timescale 1ns / 1ps

module in_dst_checker
   import drc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [YEAR_W-1:0]  req_year,
   input  logic [MONTH_W-1:0] req_month,
   input  logic [DAY_W-1:0]   req_day,
   input  logic [HOUR_W-1:0]  req_hour,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_in_dst,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 mismatch_count,
   output int                 answers_owed
);

   logic [MONTH_W-1:0] dst_month, std_month;
   logic [WEEK_W-1:0]  dst_week, std_week;
   logic [WDAY_W-1:0]  dst_wday, std_wday;
   logic [HOUR_W-1:0]  dst_hour, std_hour;
   bit                 expected_in_dst [$];
   bit                 want;

   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
      int unsigned len;
      case (m)
         2:          len = leap_year(y) ? 29 : 28;
         4, 6, 9, 11: len = 30;
         default:    len = 31;
      endcase
      return len;
   endfunction

   function automatic int unsigned first_weekday(input int unsigned y, input int unsigned m);
      int unsigned yy, shift;
      yy = y + 400;
      if (m < 3) yy = yy - 1;
      case (m)
         2, 6:    shift = 3;
         3, 11:   shift = 2;
         4, 7:    shift = 5;
         8:       shift = 1;
         9, 12:   shift = 4;
         10:      shift = 6;
         default: shift = 0;
      endcase
      return (yy + yy / 4 - yy / 100 + yy / 400 + shift + 1) % 7;
   endfunction

   function automatic int unsigned transition_key(input int unsigned y, input int unsigned m,
                                                  input int unsigned wk, input int unsigned wd,
                                                  input int unsigned hr);
      int unsigned mm, ww, dd, last;
      mm = (m < 1) ? 1 : ((m > 12) ? 12 : m);
      ww = (wk < 1) ? 1 : ((wk > 5) ? 5 : wk);
      dd = 1 + ((wd % 7) + 7 - first_weekday(y, mm)) % 7;
      if (ww == 5) begin
         last = days_in_month(y, mm);
         while (dd + 7 <= last) dd = dd + 7;
      end else begin
         dd = dd + 7 * (ww - 1);
      end
      return (mm << 10) | (dd << 5) | (hr & 31);
   endfunction

   function automatic bit predict_in_dst(input int unsigned y, input int unsigned mo,
                                         input int unsigned d, input int unsigned h);
      int unsigned now_key, start_key, stop_key;
      if (dst_month == 0) return 1'b0;
      now_key   = (mo << 10) | (d << 5) | h;
      start_key = transition_key(y, dst_month, dst_week, dst_wday, dst_hour);
      stop_key  = transition_key(y, std_month, std_week, std_wday, std_hour);
      if (stop_key < start_key) return (now_key >= start_key) || (now_key < stop_key);
      return (now_key >= start_key) && (now_key < stop_key);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         dst_month = 4'd0;
         dst_week  = 3'd1;
         dst_wday  = 3'd0;
         dst_hour  = 5'd0;
         std_month = 4'd1;
         std_week  = 3'd1;
         std_wday  = 3'd0;
         std_hour  = 5'd0;
         expected_in_dst.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_in_dst.size() == 0) begin
               $display("%0t: in_dst transfer with none owed, expected none, actual %0b",
                        $time, rsp_in_dst);
               mismatch_count++;
            end else begin
               want = expected_in_dst.pop_front();
               if (rsp_in_dst !== want) begin
                  $display("%0t: in_dst mismatch, expected %0b, actual %0b",
                           $time, want, rsp_in_dst);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_in_dst.push_back(predict_in_dst(req_year, req_month, req_day, req_hour));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_idx_type'(csr_paddr[4:2]))
               REG_DST_MONTH:   dst_month = csr_pwdata[MONTH_W-1:0];
               REG_DST_WEEK:    dst_week  = csr_pwdata[WEEK_W-1:0];
               REG_DST_WEEKDAY: dst_wday  = csr_pwdata[WDAY_W-1:0];
               REG_DST_HOUR:    dst_hour  = csr_pwdata[HOUR_W-1:0];
               REG_STD_MONTH:   std_month = csr_pwdata[MONTH_W-1:0];
               REG_STD_WEEK:    std_week  = csr_pwdata[WEEK_W-1:0];
               REG_STD_WEEKDAY: std_wday  = csr_pwdata[WDAY_W-1:0];
               REG_STD_HOUR:    std_hour  = csr_pwdata[HOUR_W-1:0];
               default: ;
            endcase
         end
      end
      answers_owed = expected_in_dst.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import drc_pkg::*;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   logic [YEAR_W-1:0]  req_year    = '0;
   logic [MONTH_W-1:0] req_month   = '0;
   logic [DAY_W-1:0]   req_day     = '0;
   logic [HOUR_W-1:0]  req_hour    = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic               rsp_in_dst;
   logic               csr_psel    = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite  = 1'b0;
   logic [4:0]         csr_paddr   = '0;
   logic [31:0]        csr_pwdata  = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int          mismatch_count;
   int          answers_owed;
   int          sender_idle_pct   = 24;
   int          receiver_idle_pct = 64;
   int          hold_off_request  = 0;
   int          hold_off_left     = 0;
   int          queries_sent      = 0;
   int unsigned rule_cfg [8];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   dst_rule_check_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_year    (req_year),
      .req_month   (req_month),
      .req_day     (req_day),
      .req_hour    (req_hour),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_in_dst  (rsp_in_dst),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   in_dst_checker in_dst_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_year       (req_year),
      .req_month      (req_month),
      .req_day        (req_day),
      .req_hour       (req_hour),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_in_dst     (rsp_in_dst),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .answers_owed   (answers_owed)
   );

   always @(negedge clock) begin
      if (hold_off_left == 0 && hold_off_request > 0) begin
         hold_off_left    = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic write_rule_reg(input reg_idx_type idx, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   task automatic drain_and_configure();
      int i;
      req_valid <= 1'b0;
      while (answers_owed != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      for (i = 0; i < 8; i++) write_rule_reg(reg_idx_type'(i), rule_cfg[i]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_query(input int unsigned y, input int unsigned mo,
                             input int unsigned d, input int unsigned h);
      if (queries_sent == 150) begin
         sender_idle_pct   = 64;
         receiver_idle_pct = 24;
      end
      if (queries_sent == 300) begin
         sender_idle_pct   = 0;
         receiver_idle_pct = 0;
      end
      if (queries_sent == 330) hold_off_request = 80;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_year  <= YEAR_W'(y);
      req_month <= MONTH_W'(mo);
      req_day   <= DAY_W'(d);
      req_hour  <= HOUR_W'(h);
      do @(posedge clock); while (!(req_valid && req_ready));
      queries_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_query();
      int unsigned kind, sel, wk, y, mo, d, h;
      kind = $urandom_range(9);
      y    = $urandom_range(3000, 1970);
      if (kind == 0) begin
         y  = $urandom_range(4095);
         mo = $urandom_range(15);
         d  = $urandom_range(31);
         h  = $urandom_range(31);
      end else if (kind <= 5) begin
         sel = $urandom_range(1) ? 0 : 4;
         wk  = rule_cfg[sel + 1];
         mo  = rule_cfg[sel];
         if (wk < 1 || wk > 4) d = $urandom_range(31, 22);
         else d = $urandom_range(7 * wk, 7 * wk - 6);
         h = (rule_cfg[sel + 3] - $urandom_range(1)) & 31;
         if (kind == 1) y = $urandom_range(4095);
      end else begin
         mo = $urandom_range(12, 1);
         d  = $urandom_range(31, 1);
         h  = $urandom_range(23);
      end
      send_query(y, mo, d, h);
   endtask

   initial begin
      int phase, n, i;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_query(2024, 6, 15, 12);
      send_query(0, 0, 0, 0);
      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: rule_cfg = '{3, 2, 0, 2, 11, 1, 0, 2};
            1: rule_cfg = '{10, 1, 0, 2, 4, 1, 0, 3};
            2: rule_cfg = '{3, 5, 0, 1, 10, 5, 0, 1};
            3: rule_cfg = '{15, 7, 7, 31, 0, 0, 7, 31};
            4: rule_cfg = '{1, 0, 6, 0, 12, 6, 6, 23};
            5: rule_cfg = '{6, 3, 2, 5, 6, 3, 2, 5};
            default: begin
               for (i = 0; i < 8; i += 4) begin
                  rule_cfg[i]     = $urandom_range(15);
                  rule_cfg[i + 1] = $urandom_range(7);
                  rule_cfg[i + 2] = $urandom_range(7);
                  rule_cfg[i + 3] = $urandom_range(31);
               end
               if (phase == 6) rule_cfg[0] = 0;
            end
         endcase
         drain_and_configure();
         if (phase == 0) begin
            send_query(2024, 3, 10, 1);
            send_query(2024, 3, 10, 2);
            send_query(2024, 11, 3, 1);
            send_query(2024, 11, 3, 2);
            send_query(1970, 1, 1, 0);
            send_query(3000, 12, 31, 23);
            send_query(4095, 15, 31, 31);
            send_query(0, 0, 0, 0);
            send_query(2000, 3, 12, 2);
            send_query(1900, 3, 11, 2);
            send_query(2100, 11, 7, 1);
            send_query(2023, 3, 12, 2);
            send_query(2023, 3, 11, 23);
            send_query(2024, 7, 4, 12);
            send_query(2024, 2, 29, 5);
         end
         for (n = 0; n < 48; n++) send_random_query();
      end
      req_valid <= 1'b0;
      while (answers_owed != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/drc_pkg.sv
rtl/core/dst_rule_check_core.sv
tb/in_dst_checker.sv
tb/tb.sv
